[rtl/vsa_pkg.sv]
// ----------------------------------------------------------------------------
// vsa_pkg: shared definitions for the voice steal allocator
// Request kinds, field widths, clamp limits and the control bundle that the
// top level broadcasts to every voice cell.
// ----------------------------------------------------------------------------
package vsa_pkg;

  // Request kinds carried on in_tuser.
  localparam logic [1:0] OP_PLAY = 2'd0;
  localparam logic [1:0] OP_DONE = 2'd1;
  localparam logic [1:0] OP_STOP = 2'd2;

  localparam int OP_W    = 2;
  localparam int SND_W   = 16;
  localparam int PCT_W   = 16;
  localparam int POS_W   = 32;
  localparam int DONE_W  = 2;
  localparam int VOICE_W = 2;
  localparam int VOL_W   = 7;
  localparam int PITCH_W = 8;

  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 120;

  localparam logic signed [PCT_W-1:0] VOL_MIN   = 16'sd0;
  localparam logic signed [PCT_W-1:0] VOL_MAX   = 16'sd100;
  localparam logic signed [PCT_W-1:0] PITCH_MIN = 16'sd50;
  localparam logic signed [PCT_W-1:0] PITCH_MAX = 16'sd150;

  typedef struct packed {
    logic              en;
    logic              play;
    logic              done;
    logic              stop;
    logic [DONE_W-1:0] done_voice;
  } vsa_ctl_t;

endpackage

[rtl/voice_steal_allocator.sv]
// ----------------------------------------------------------------------------
// voice_steal_allocator: least recently used voice allocation with stealing
// Keeps the voice priority order in a row of cells and assigns play requests.
// ----------------------------------------------------------------------------
// Input channel: in_tuser carries the request kind (play, voice finished,
// stop all) and in_tdata the sound, volume, pitch, position and finished
// voice. Only play requests produce a result on the output channel, which
// reports the chosen voice, whether the buffer must be reloaded, whether a
// playing voice was stolen, and the clamped volume and pitch with the
// position passed through.
// Each request is decided in the cycle it is accepted: the cells compare
// their voice against the request in parallel, a picker chooses one
// position, and the cells behind it take their neighbor's contents in the
// same edge that loads the result into the output register. One request
// can be taken every cycle while the output is empty or the receiver takes it.
// A single output register holds the result; while it is full and the
// receiver stalls, in_tready stays low, including for requests that give
// no result.
// Reset puts the voices in order 0, 1, 2, ..., all idle with no sound
// attached, and empties the output register.
// ----------------------------------------------------------------------------
module voice_steal_allocator #(
  parameter int VOICES        = 4,
  parameter int SOUND_ID_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // op
  input  logic [vsa_pkg::OP_W-1:0]        in_tuser,
  // sound_id, volume_in, pitch_in, pos_x_in, pos_y_in, pos_z_in, done_voice
  input  logic [vsa_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // voice, reload_buffer, stolen, volume_out, pitch_out, pos_x/y/z_out
  output logic [vsa_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int VID_W = $clog2(VOICES);
  localparam int SND_W = SOUND_ID_BITS;

  // Unpacked request fields.
  logic [vsa_pkg::SND_W-1:0]          in_sound;
  logic signed [vsa_pkg::PCT_W-1:0]   in_volume;
  logic signed [vsa_pkg::PCT_W-1:0]   in_pitch;
  logic [vsa_pkg::POS_W-1:0]          in_pos_x, in_pos_y, in_pos_z;
  logic [vsa_pkg::DONE_W-1:0]         in_done;

  assign in_sound  = in_tdata[15:0];
  assign in_volume = in_tdata[31:16];
  assign in_pitch  = in_tdata[47:32];
  assign in_pos_x  = in_tdata[79:48];
  assign in_pos_y  = in_tdata[111:80];
  assign in_pos_z  = in_tdata[143:112];
  assign in_done   = in_tdata[145:144];

  logic              accept;
  vsa_pkg::vsa_ctl_t ctl;
  logic [SND_W-1:0]  req_snd;

  assign accept  = in_tvalid && in_tready;
  assign req_snd = SND_W'(in_sound);

  always_comb begin
    ctl.en         = accept;
    ctl.play       = (in_tuser == vsa_pkg::OP_PLAY);
    ctl.done       = (in_tuser == vsa_pkg::OP_DONE);
    ctl.stop       = (in_tuser == vsa_pkg::OP_STOP);
    ctl.done_voice = in_done;
  end

  logic [VID_W-1:0] cell_vid   [VOICES];
  logic [SND_W-1:0] cell_snd   [VOICES];
  logic             cell_valid [VOICES];
  logic             cell_play  [VOICES];
  logic [VOICES-1:0] idle_v, match_v, sel_oh, shift_mask;

  logic [VID_W-1:0] sel_vid;
  logic             sel_valid_match;
  logic             sel_play;

  for (genvar i = 0; i < VOICES; i++) begin : g_cell
    logic [VID_W-1:0] nb_vid;
    logic [SND_W-1:0] nb_snd;
    logic             nb_valid;
    logic             nb_play;

    if (i == VOICES - 1) begin : g_tail
      // The back of the order receives the chosen voice, now playing.
      assign nb_vid   = sel_vid;
      assign nb_snd   = req_snd;
      assign nb_valid = 1'b1;
      assign nb_play  = 1'b1;
    end else begin : g_body
      assign nb_vid   = cell_vid[i+1];
      assign nb_snd   = cell_snd[i+1];
      assign nb_valid = cell_valid[i+1];
      assign nb_play  = cell_play[i+1];
    end

    vsa_cell #(
      .VID_W    (VID_W),
      .SND_W    (SND_W),
      .INIT_VID (VID_W'(i))
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .req_snd  (req_snd),
      .shift    (shift_mask[i]),
      .nb_vid   (nb_vid),
      .nb_snd   (nb_snd),
      .nb_valid (nb_valid),
      .nb_play  (nb_play),
      .vid      (cell_vid[i]),
      .snd      (cell_snd[i]),
      .valid    (cell_valid[i]),
      .play     (cell_play[i]),
      .idle     (idle_v[i]),
      .match    (match_v[i])
    );
  end

  vsa_select #(
    .VOICES (VOICES)
  ) u_select (
    .idle       (idle_v),
    .match      (match_v),
    .sel_oh     (sel_oh),
    .shift_mask (shift_mask)
  );

  // sel_oh is one-hot, so an OR of the gated cells reads the chosen one.
  always_comb begin
    sel_vid         = '0;
    sel_valid_match = 1'b0;
    sel_play        = 1'b0;
    for (int i = 0; i < VOICES; i++) begin
      sel_vid         = sel_vid | (cell_vid[i] & {VID_W{sel_oh[i]}});
      sel_valid_match = sel_valid_match | (match_v[i] & sel_oh[i]);
      sel_play        = sel_play | (cell_play[i] & sel_oh[i]);
    end
  end

  logic [vsa_pkg::VOL_W-1:0]   vol_clamp;
  logic [vsa_pkg::PITCH_W-1:0] pitch_clamp;

  always_comb begin
    if (in_volume < vsa_pkg::VOL_MIN) begin
      vol_clamp = vsa_pkg::VOL_W'(vsa_pkg::VOL_MIN);
    end else if (in_volume > vsa_pkg::VOL_MAX) begin
      vol_clamp = vsa_pkg::VOL_W'(vsa_pkg::VOL_MAX);
    end else begin
      vol_clamp = in_volume[vsa_pkg::VOL_W-1:0];
    end
    if (in_pitch < vsa_pkg::PITCH_MIN) begin
      pitch_clamp = vsa_pkg::PITCH_W'(vsa_pkg::PITCH_MIN);
    end else if (in_pitch > vsa_pkg::PITCH_MAX) begin
      pitch_clamp = vsa_pkg::PITCH_W'(vsa_pkg::PITCH_MAX);
    end else begin
      pitch_clamp = in_pitch[vsa_pkg::PITCH_W-1:0];
    end
  end

  // Output register.
  logic                            out_valid_r, out_valid_nxt;
  logic [vsa_pkg::OUT_DATA_W-1:0]  out_data_r, out_data_nxt;
  logic                            load_out;

  assign in_tready = !out_valid_r || out_tready;
  assign load_out  = accept && ctl.play;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_data_nxt[1:0]    = vsa_pkg::VOICE_W'(sel_vid);
      out_data_nxt[2]      = !sel_valid_match;
      out_data_nxt[3]      = sel_play;
      out_data_nxt[10:4]   = vol_clamp;
      out_data_nxt[18:11]  = pitch_clamp;
      out_data_nxt[50:19]  = in_pos_x;
      out_data_nxt[82:51]  = in_pos_y;
      out_data_nxt[114:83] = in_pos_z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[rtl/vsa_cell.sv]
// ----------------------------------------------------------------------------
// vsa_cell: one position of the voice priority order
// Holds the voice number at this position with its attached sound and flags.
// On a play request at or after the chosen position it takes its neighbor's
// contents, so the order closes up and the chosen voice lands at the back.
// ----------------------------------------------------------------------------
module vsa_cell #(
  parameter int               VID_W    = 2,
  parameter int               SND_W    = 16,
  parameter logic [VID_W-1:0] INIT_VID = '0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  vsa_pkg::vsa_ctl_t ctl,
  input  logic [SND_W-1:0] req_snd,
  input  logic             shift,
  input  logic [VID_W-1:0] nb_vid,
  input  logic [SND_W-1:0] nb_snd,
  input  logic             nb_valid,
  input  logic             nb_play,
  output logic [VID_W-1:0] vid,
  output logic [SND_W-1:0] snd,
  output logic             valid,
  output logic             play,
  output logic             idle,
  output logic             match
);

  localparam int CMP_W = (VID_W > vsa_pkg::DONE_W) ? VID_W : vsa_pkg::DONE_W;

  logic [VID_W-1:0] vid_r, vid_nxt;
  logic [SND_W-1:0] snd_r, snd_nxt;
  logic             valid_r, valid_nxt;
  logic             play_r, play_nxt;
  logic             done_hit;

  assign done_hit = (CMP_W'(vid_r) == CMP_W'(ctl.done_voice));

  always_comb begin
    vid_nxt   = vid_r;
    snd_nxt   = snd_r;
    valid_nxt = valid_r;
    play_nxt  = play_r;
    if (ctl.en) begin
      if (ctl.play && shift) begin
        vid_nxt   = nb_vid;
        snd_nxt   = nb_snd;
        valid_nxt = nb_valid;
        play_nxt  = nb_play;
      end else if (ctl.done && done_hit) begin
        play_nxt = 1'b0;
      end else if (ctl.stop) begin
        play_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vid_r   <= INIT_VID;
      valid_r <= 1'b0;
      play_r  <= 1'b0;
    end else begin
      vid_r   <= vid_nxt;
      valid_r <= valid_nxt;
      play_r  <= play_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snd_r <= snd_nxt;
  end

  assign vid   = vid_r;
  assign snd   = snd_r;
  assign valid = valid_r;
  assign play  = play_r;
  assign idle  = !play_r;
  assign match = valid_r && (snd_r == req_snd);

endmodule

[rtl/vsa_select.sv]
// ----------------------------------------------------------------------------
// vsa_select: picks the position that a play request takes
// First idle position from the front, else the last position holding the
// requested sound, else the front. Also gives the mask of positions that
// close up behind the chosen one.
// ----------------------------------------------------------------------------
module vsa_select #(
  parameter int VOICES = 4
) (
  input  logic [VOICES-1:0] idle,
  input  logic [VOICES-1:0] match,
  output logic [VOICES-1:0] sel_oh,
  output logic [VOICES-1:0] shift_mask
);

  logic [VOICES-1:0] first_idle;
  logic [VOICES-1:0] match_rev;
  logic [VOICES-1:0] last_rev;
  logic [VOICES-1:0] last_match;

  assign first_idle = idle & (~idle + VOICES'(1));

  // Lowest set bit of the reversed vector is the highest set bit of match.
  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      match_rev[i] = match[VOICES-1-i];
    end
  end

  assign last_rev = match_rev & (~match_rev + VOICES'(1));

  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      last_match[i] = last_rev[VOICES-1-i];
    end
  end

  always_comb begin
    if (|idle) begin
      sel_oh = first_idle;
    end else if (|match) begin
      sel_oh = last_match;
    end else begin
      sel_oh = VOICES'(1);
    end
  end

  // sel_oh is never zero, so this marks the chosen position and all after it.
  assign shift_mask = ~(sel_oh - VOICES'(1));

endmodule

[rtl/vsa_checker.sv]
// ----------------------------------------------------------------------------
// vsa_checker: port-level checks for the voice steal allocator
// Watches the two channels and checks result ranges and request handling.
// ----------------------------------------------------------------------------
module vsa_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [vsa_pkg::OP_W-1:0]       in_tuser,
  input logic [vsa_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [vsa_pkg::OUT_DATA_W-1:0] out_tdata
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Every accepted play request shows a result on the next cycle.
  a_play_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == vsa_pkg::OP_PLAY) |=> out_tvalid)
    else $error("play request gave no result");

  // A request that gives no result does not refill an empty output.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !(in_tvalid && in_tready && (in_tuser == vsa_pkg::OP_PLAY))
    |=> !out_tvalid)
    else $error("result without a play request");

  // Volume and pitch of a result stay inside their clamp limits.
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[10:4] <= 7'd100) &&
                   (out_tdata[18:11] >= 8'd50) && (out_tdata[18:11] <= 8'd150))
    else $error("clamped field out of range");

endmodule

bind voice_steal_allocator vsa_checker u_vsa_checker (.*);
